@@ rtl/mmn_pkg.sv @@
// mmn_pkg: shared widths, command codes and types of the min-max normalizer.
// No dependencies; every other rtl file but mmn_ram imports it.
`default_nettype none

package mmn_pkg;

  localparam int SAMPLE_W = 24;   // signed Q7.16 sample
  localparam int IDX_W    = 12;   // grid index
  localparam int SCALED_W = 16;   // unsigned Q0.16 result

  // sample store, power of two; the index wraps modulo its depth
  localparam int DEPTH    = 4096;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDXEXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  // read queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one quotient bit per divider step
  localparam int DIV_STEPS = SCALED_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_e;

  // read item waiting for the back end: sample plus range snapshot
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic        [IDX_W-1:0]    index;
  } rd_item_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDXEXT_W-1:0] ext;
    ext = IDXEXT_W'(idx);
    return ext[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/mmn_ram.sv @@
// mmn_ram: generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module mmn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/mmn_front.sv @@
// mmn_front: accepts items, stores samples, tracks running min/max and
// turns reads into queue items. Depends on mmn_pkg and mmn_ram.
`default_nettype none

module mmn_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  output logic                                     full_o,
  input  wire logic                                cmd_i,
  input  wire logic signed [mmn_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic        [mmn_pkg::IDX_W-1:0]    index_i,
  input  wire logic                                first_i,
  output logic                                     enq_o,
  output mmn_pkg::rd_item_t                        enq_item_o,
  input  wire mmn_pkg::q_stat_t                    q_stat_i
);
  import mmn_pkg::*;

  logic                       accept;
  logic                       is_load;
  logic                       is_read;
  logic [QCNT_W:0]            occ;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;
  logic                       pend_q;
  logic signed [SAMPLE_W-1:0] pend_lo_q;
  logic signed [SAMPLE_W-1:0] pend_hi_q;
  logic [IDX_W-1:0]           pend_idx_q;

  // a read in flight to the RAM counts against queue room
  assign occ     = (QCNT_W+1)'(q_stat_i.count) + (QCNT_W+1)'(pend_q);
  assign full_o  = occ >= (QCNT_W+1)'(QDEPTH);
  assign accept  = push_i && !full_o;
  assign is_load = accept && (cmd_i == CMD_LOAD);
  assign is_read = accept && (cmd_i == CMD_READ);

  mmn_ram #(
    .Width (SAMPLE_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (is_load),
    .addr_i  (slot_of(index_i)),
    .wdata_i (sample_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (is_load) begin
      if (first_i) begin
        min_d = sample_i;
        max_d = sample_i;
      end else begin
        if (sample_i < min_q) min_d = sample_i;
        if (sample_i > max_q) max_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      pend_q <= is_read;
    end
  end

  // range is captured at accept so later loads do not affect this read
  always_ff @(posedge clk_i) begin
    if (is_read) begin
      pend_lo_q  <= min_q;
      pend_hi_q  <= max_q;
      pend_idx_q <= index_i;
    end
  end

  assign enq_o            = pend_q;
  assign enq_item_o.x     = $signed(ram_rdata);
  assign enq_item_o.lo    = pend_lo_q;
  assign enq_item_o.hi    = pend_hi_q;
  assign enq_item_o.index = pend_idx_q;

endmodule

`default_nettype wire

@@ rtl/mmn_queue.sv @@
// mmn_queue: short FIFO of read items between front and back.
// Depends on mmn_pkg.
`default_nettype none

module mmn_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              enq_i,
  input  wire mmn_pkg::rd_item_t enq_item_i,
  input  wire logic              deq_i,
  output mmn_pkg::rd_item_t      head_o,
  output mmn_pkg::q_stat_t       stat_o
);
  import mmn_pkg::*;

  rd_item_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_deq;

  // front never pushes into a full queue: it reserves room before accepting
  assign do_deq = deq_i && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (enq_i && !do_deq) count_d = count_q + 1'b1;
    if (!enq_i && do_deq) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq_i)  wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_deq) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_ptr_q] <= enq_item_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

@@ rtl/mmn_back.sv @@
// mmn_back: classifies a read item, runs a restoring divider one quotient
// bit per cycle and holds the result register. Depends on mmn_pkg.
`default_nettype none

module mmn_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mmn_pkg::q_stat_t                 q_stat_i,
  input  wire mmn_pkg::rd_item_t                head_i,
  output logic                                  deq_o,
  input  wire logic                             pop_i,
  output logic                                  empty_o,
  output logic [mmn_pkg::SCALED_W-1:0]          scaled_o,
  output logic [mmn_pkg::IDX_W-1:0]             out_index_o,
  output logic                                  flat_o
);
  import mmn_pkg::*;

  back_state_e state_q, state_d;

  logic signed [SAMPLE_W:0] num;
  logic signed [SAMPLE_W:0] den;
  logic                     is_flat;
  logic                     trivial;
  logic [SCALED_W-1:0]      triv_val;
  logic                     step;
  logic                     load_out;
  logic                     out_free;
  logic [SAMPLE_W:0]        rem_sh;
  logic                     rem_ge;
  logic [SAMPLE_W:0]        rem_sub;

  logic [SAMPLE_W-1:0]      rem_q;
  logic [SAMPLE_W-1:0]      den_q;
  logic [SCALED_W-1:0]      quo_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     wflat_q;
  logic [DCNT_W-1:0]        cnt_q;

  logic                     out_valid_q;
  logic [SCALED_W-1:0]      scaled_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_flat_q;

  // classification of the head item
  assign num     = $signed({head_i.x[SAMPLE_W-1], head_i.x})
                 - $signed({head_i.lo[SAMPLE_W-1], head_i.lo});
  assign den     = $signed({head_i.hi[SAMPLE_W-1], head_i.hi})
                 - $signed({head_i.lo[SAMPLE_W-1], head_i.lo});
  assign is_flat = (head_i.hi == head_i.lo);

  always_comb begin
    trivial  = 1'b1;
    triv_val = '0;
    if (is_flat || den[SAMPLE_W] || num[SAMPLE_W] || (num == '0)) begin
      triv_val = '0;
    end else if (num >= den) begin
      triv_val = '1;
    end else begin
      trivial = 1'b0;
    end
  end

  // one restoring step: remainder stays below the divisor
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) state_d = trivial ? BK_HOLD : BK_DIV;
      end
      BK_DIV: begin
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = BK_HOLD;
      end
      BK_HOLD: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    deq_o    = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: deq_o    = !q_stat_i.empty;
      BK_DIV:  step     = 1'b1;
      BK_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (deq_o) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_o) begin
      rem_q   <= num[SAMPLE_W-1:0];
      den_q   <= den[SAMPLE_W-1:0];
      quo_q   <= triv_val;
      idx_q   <= head_i.index;
      wflat_q <= is_flat;
    end else if (step) begin
      rem_q <= rem_ge ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      quo_q <= {quo_q[SCALED_W-2:0], rem_ge};
    end
    if (load_out) begin
      scaled_q   <= quo_q;
      out_idx_q  <= idx_q;
      out_flat_q <= wflat_q;
    end
  end

  assign empty_o     = !out_valid_q;
  assign scaled_o    = scaled_q;
  assign out_index_o = out_idx_q;
  assign flat_o      = out_flat_q;

endmodule

`default_nettype wire

@@ rtl/minmax_normalizer.sv @@
// A read skips the divider when the range is flat or the sample is at or below min or at or
// above max; other reads go through the 16-step divider. Loads enter one per cycle while
// full is low; reads are divided one at a time by the shared divider, and the back end
// takes no new read until the result register has room, so results wait to be popped.
// A 4-entry read queue lets loads and reads keep entering while the divider works.
// Reset (rst_ni, async, active low) clears min/max to 0 and empties queue and output;
// the sample store is not cleared and an entry must be loaded before it is read.
`default_nettype none

module minmax_normalizer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                cmd_i,
  input  wire logic signed [mmn_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic        [mmn_pkg::IDX_W-1:0]    index_i,
  input  wire logic                                first_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic             [mmn_pkg::SCALED_W-1:0] scaled_o,
  output logic             [mmn_pkg::IDX_W-1:0]    out_index_o,
  output logic                                     flat_o
);
  import mmn_pkg::*;

  logic     enq;
  rd_item_t enq_item;
  logic     deq;
  rd_item_t head;
  q_stat_t  q_stat;

  mmn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .index_i    (index_i),
    .first_i    (first_i),
    .enq_o      (enq),
    .enq_item_o (enq_item),
    .q_stat_i   (q_stat)
  );

  mmn_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_item_i (enq_item),
    .deq_i      (deq),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  mmn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .deq_o       (deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .scaled_o    (scaled_o),
    .out_index_o (out_index_o),
    .flat_o      (flat_o)
  );

endmodule

`default_nettype wire

@@ rtl/mmn_checker.sv @@
// mmn_checker: port-level assertions for minmax_normalizer, bound to the top.
// Depends on mmn_pkg.
`default_nettype none

module mmn_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                push,
  input wire logic                                full,
  input wire logic                                cmd_i,
  input wire logic                                empty,
  input wire logic                                pop,
  input wire logic        [mmn_pkg::SCALED_W-1:0] scaled_o,
  input wire logic        [mmn_pkg::IDX_W-1:0]    out_index_o,
  input wire logic                                flat_o
);
  import mmn_pkg::*;

  // reads accepted but not yet popped; at most queue (shared with the RAM stage) + divider + output
  localparam int MaxOut = QDEPTH + 2;

  logic [QCNT_W+1:0] outst_q;
  logic              rd_acc;
  logic              pop_acc;

  assign rd_acc  = push && !full && (cmd_i == CMD_READ);
  assign pop_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (rd_acc && !pop_acc) begin
      outst_q <= outst_q + 1'b1;
    end else if (!rd_acc && pop_acc) begin
      outst_q <= outst_q - 1'b1;
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outst_q != '0))
    else $error("result shown with no read outstanding");

  a_full_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outst_q == (QCNT_W+2)'(MaxOut)) |-> full)
    else $error("input open with every read slot taken");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && flat_o) |-> (scaled_o == '0))
    else $error("flat range with nonzero scaled value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(scaled_o) && $stable(out_index_o)
                          && $stable(flat_o)))
    else $error("waiting result changed before pop");

endmodule

bind minmax_normalizer mmn_checker u_mmn_checker (.*);

`default_nettype wire

@@ sim/minmax_normalizer_tb.sv @@
// minmax_normalizer_tb: self-checking bench for the min-max normalizer.
// Depends on rtl/mmn_pkg.sv and rtl/minmax_normalizer.sv; tracks range and store itself.
`timescale 1ns / 100ps

module minmax_normalizer_tb;
  import mmn_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    SPREAD_WIDE,
    SPREAD_NARROW,
    SPREAD_LEVEL,
    SPREAD_EXTREME
  } spread_e;

  typedef struct packed {
    logic [SCALED_W-1:0] scaled;
    logic [IDX_W-1:0]    index;
    logic                flat;
  } norm_result_t;

  logic                       clk_i    = 1'b0;
  logic                       rst_ni   = 1'b0;
  logic                       push     = 1'b0;
  logic                       cmd_i    = CMD_LOAD;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic        [IDX_W-1:0]    index_i  = '0;
  logic                       first_i  = 1'b0;
  logic                       pop      = 1'b0;
  logic                       full;
  logic                       empty;
  logic [SCALED_W-1:0]        scaled_o;
  logic [IDX_W-1:0]           out_index_o;
  logic                       flat_o;

  // predictor state
  logic signed [SAMPLE_W-1:0] grid_store [DEPTH];
  logic                       grid_loaded [DEPTH];
  logic [IDX_W-1:0]           loaded_slots[$];
  logic signed [SAMPLE_W-1:0] range_lo = '0;
  logic signed [SAMPLE_W-1:0] range_hi = '0;
  norm_result_t               pending_norm[$];

  int   errors = 0;
  int   items_sent = 0;
  bit   tx_bursty = 1'b1;
  int   burst_left = 1;
  bit   rx_free = 1'b0;
  int   rx_hold_cycles = 0;
  int   rx_phase = 0;
  logic [15:0] rx_mask = '1;

  minmax_normalizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .sample_i    (sample_i),
    .index_i     (index_i),
    .first_i     (first_i),
    .empty       (empty),
    .pop         (pop),
    .scaled_o    (scaled_o),
    .out_index_o (out_index_o),
    .flat_o      (flat_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

  // floor((x - lo) / (hi - lo)) in Q0.16, clipped to [0, 65535]
  function automatic logic [SCALED_W-1:0] normalize(input logic signed [SAMPLE_W-1:0] x,
                                                   input logic signed [SAMPLE_W-1:0] lo,
                                                   input logic signed [SAMPLE_W-1:0] hi);
    longint num;
    longint den;
    longint q;
    num = longint'(x) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return '1;
    q = (num <<< 16) / den;
    return q[SCALED_W-1:0];
  endfunction

  task automatic track_item(input logic c, input logic signed [SAMPLE_W-1:0] s,
                            input logic [IDX_W-1:0] idx, input logic f);
    int slot;
    norm_result_t want;
    slot = int'(idx) % DEPTH;
    if (c == CMD_LOAD) begin
      grid_store[slot] = s;
      if (!grid_loaded[slot]) begin
        grid_loaded[slot] = 1'b1;
        loaded_slots = {loaded_slots, idx};
      end
      if (f) begin
        range_lo = s;
        range_hi = s;
      end else begin
        if (s < range_lo) range_lo = s;
        if (s > range_hi) range_hi = s;
      end
    end else begin
      want.index = idx;
      want.flat  = (range_hi == range_lo);
      want.scaled = want.flat ? '0 : normalize(grid_store[slot], range_lo, range_hi);
      pending_norm = {pending_norm, want};
    end
  endtask

  // Call at a rising edge; returns at the edge where the item was taken, or after a burst gap.
  task automatic send_item(input logic c, input logic signed [SAMPLE_W-1:0] s,
                           input logic [IDX_W-1:0] idx, input logic f);
    push     <= 1'b1;
    cmd_i    <= c;
    sample_i <= s;
    index_i  <= idx;
    first_i  <= f;
    do @(posedge clk_i); while (full);
    track_item(c, s, idx, f);
    items_sent++;
    if (tx_bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic load_sample(input logic signed [SAMPLE_W-1:0] s,
                             input logic [IDX_W-1:0] idx, input logic f);
    send_item(CMD_LOAD, s, idx, f);
  endtask

  // sample and first are don't-care on a read, so fill them with junk
  task automatic read_norm(input logic [IDX_W-1:0] idx);
    send_item(CMD_READ, SAMPLE_W'($urandom), idx, 1'($urandom));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_norm.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input spread_e spread, input logic signed [SAMPLE_W-1:0] base, input int span);
    case (spread)
      SPREAD_WIDE:   return SAMPLE_W'($urandom);
      SPREAD_NARROW: return base + SAMPLE_W'($urandom_range(0, span));
      SPREAD_LEVEL:  return base;
      default: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return base;
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // One grid: a restart load, more loads with some reads mixed in, then reads. Some frames skip the
  // restart or read stale entries from older grids.
  task automatic run_frame();
    spread_e spread;
    logic signed [SAMPLE_W-1:0] base;
    logic [IDX_W-1:0] origin;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] frame_idx[$];
    int span;
    int n_loads;
    int n_reads;
    bit restart;
    spread  = spread_e'($urandom_range(0, 3));
    base    = SAMPLE_W'($urandom);
    span    = $urandom_range(1, 300);
    origin  = IDX_W'($urandom);
    n_loads = $urandom_range(1, 24);
    n_reads = $urandom_range(1, 12);
    restart = ($urandom_range(0, 7) != 0);
    for (int j = 0; j <= n_loads; j++) begin
      idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : origin + IDX_W'(j);
      load_sample(pick_sample(spread, base, span), idx, restart && (j == 0));
      frame_idx = {frame_idx, idx};
      if ($urandom_range(0, 4) == 0)
        read_norm(frame_idx[$urandom_range(0, frame_idx.size() - 1)]);
    end
    repeat (n_reads) begin
      if ($urandom_range(0, 5) == 0)
        read_norm(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
      else
        read_norm(frame_idx[$urandom_range(0, frame_idx.size() - 1)]);
    end
  endtask

  task automatic test_directed_cases();
    load_sample('0, 12'd0, 1'b0);            // reset range is 0..0
    read_norm(12'd0);                        // flat
    load_sample(S_MAX, 12'd4095, 1'b0);
    read_norm(12'd4095);                     // x == max saturates
    read_norm(12'd0);                        // x == min
    load_sample(S_MIN, 12'd1, 1'b0);
    read_norm(12'd0);
    read_norm(12'd1);
    send_item(CMD_READ, 24'sh5a5a5a, 12'd4095, 1'b1);
    load_sample(24'sh123456, 12'd2, 1'b1);   // restart, flat again
    read_norm(12'd2);
    read_norm(12'd1);
    load_sample(24'sd2000000, 12'd3, 1'b0);
    load_sample(24'sd1500000, 12'd5, 1'b0);
    read_norm(12'd5);
    read_norm(12'd1);                        // below min after restart
    read_norm(12'd4095);                     // above max
    read_norm(12'd2);
    read_norm(12'd3);
    load_sample(-24'sd5, 12'd6, 1'b1);
    load_sample(-24'sd4, 12'd7, 1'b0);       // range of one lsb
    read_norm(12'd6);
    read_norm(12'd7);
    load_sample(-24'sd3, 12'd9, 1'b0);
    read_norm(12'd7);                        // exactly one half
  endtask

  task automatic test_random_frames(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) run_frame();
  endtask

  // receiver holds off while reads keep coming, so the read queue fills
  task automatic test_input_stall();
    tx_bursty = 1'b0;
    rx_hold_cycles = 300;
    load_sample(SAMPLE_W'($urandom), IDX_W'($urandom), 1'b0);
    repeat (34) read_norm(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
    tx_bursty = 1'b1;
  endtask

  task automatic test_full_rate(input int n_items);
    tx_bursty = 1'b0;
    rx_free = 1'b1;
    test_random_frames(n_items);
    tx_bursty = 1'b1;
    rx_free = 1'b0;
  endtask

  // receiver: long holds on request, pop held high when rx_free is set, otherwise a random 16-bit mask
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      pop <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else if (rx_free) begin
      pop <= 1'b1;
    end else begin
      if (rx_phase == 0) rx_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      pop <= rx_mask[rx_phase];
      rx_phase = (rx_phase + 1) % 16;
    end
  end

  always @(posedge clk_i) begin : check_results
    norm_result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_norm.size() == 0) begin
        errors++;
        $display("%0t: unexpected result scaled %h index %0d flat %b",
                 $time, scaled_o, out_index_o, flat_o);
      end else begin
        want = pending_norm.pop_front();
        if (scaled_o !== want.scaled) begin
          errors++;
          $display("%0t: scaled expected %h got %h (index %0d)",
                   $time, want.scaled, scaled_o, want.index);
        end
        if (out_index_o !== want.index) begin
          errors++;
          $display("%0t: out_index expected %0d got %0d", $time, want.index, out_index_o);
        end
        if (flat_o !== want.flat) begin
          errors++;
          $display("%0t: flat expected %b got %b (index %0d)",
                   $time, want.flat, flat_o, want.index);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) grid_loaded[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 12);

    test_directed_cases();
    wait_drained();
    test_random_frames(700);
    wait_drained();
    test_input_stall();
    wait_drained();
    test_full_rate(400);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_norm.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
